// ===== rtl/core/pfa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the paged frame allocator.
package pfa_pkg;

   // Input operation codes
   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // Result kinds
   localparam logic [2:0] KIND_QUEUED    = 3'd0;
   localparam logic [2:0] KIND_OVERSIZED = 3'd1;
   localparam logic [2:0] KIND_FULL      = 3'd2;
   localparam logic [2:0] KIND_ADMITTED  = 3'd3;
   localparam logic [2:0] KIND_TICK_DONE = 3'd4;

   // Register indexes
   localparam logic [1:0] CSR_MEM_SIZE  = 2'd0;
   localparam logic [1:0] CSR_PAGE_SEL  = 2'd1;

   // Page size selects
   localparam logic [1:0] PSEL_100 = 2'd0;
   localparam logic [1:0] PSEL_200 = 2'd1;
   localparam logic [1:0] PSEL_400 = 2'd2;

   // x / (100 << s) == ((x >> (2 + s)) * 20972) >> 19, exact for x below 2^17:
   // the power-of-two part is shifted off, the reciprocal handles the 25
   localparam int RECIP       = 20972;
   localparam int RECIP_SHIFT = 19;

   localparam int PAGE_W = 10;

   // Wave kind traveling down the frame cells
   typedef struct packed {
      logic valid;
      logic alloc;   // 1: allocation wave, 0: release wave
   } tok_ctl_type;

endpackage

// ===== rtl/core/pfa_cell.sv =====
`timescale 1ns / 1ps
// One frame slot of the allocator chain: busy flag, end time, wave stage.
module pfa_cell
   import pfa_pkg::*;
#(
   parameter int TIME_BITS = 24,
   parameter int CNT_W     = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic                  enable,
   input  tok_ctl_type           ctl_in,
   input  logic [PAGE_W-1:0]     left_in,
   input  logic [TIME_BITS-1:0]  stamp_in,
   input  logic [CNT_W-1:0]      cnt_in,
   output tok_ctl_type           ctl_out,
   output logic [PAGE_W-1:0]     left_out,
   output logic [TIME_BITS-1:0]  stamp_out,
   output logic [CNT_W-1:0]      cnt_out
);

   logic                 busy_ff, busy_in;
   logic [TIME_BITS-1:0] end_ff, end_in;
   tok_ctl_type          ctl_ff;
   logic [PAGE_W-1:0]    left_ff, left_in_nxt;
   logic [TIME_BITS-1:0] stamp_ff;
   logic [CNT_W-1:0]     cnt_ff, cnt_in_nxt;
   logic                 hit_rel, take;

   assign hit_rel = ctl_in.valid && !ctl_in.alloc && busy_ff && (end_ff == stamp_in);
   assign take    = ctl_in.valid && ctl_in.alloc && enable && !busy_ff && (left_in != '0);

   always_comb begin
      busy_in     = busy_ff;
      end_in      = end_ff;
      left_in_nxt = left_in;
      cnt_in_nxt  = cnt_in;
      if (hit_rel) begin
         busy_in    = 1'b0;
         cnt_in_nxt = cnt_in + CNT_W'(1);
      end
      if (take) begin
         busy_in     = 1'b1;
         end_in      = stamp_in;
         left_in_nxt = left_in - PAGE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         busy_ff <= 1'b0;
         ctl_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         ctl_ff  <= ctl_in;
      end
      end_ff   <= end_in;
      left_ff  <= left_in_nxt;
      stamp_ff <= stamp_in;
      cnt_ff   <= cnt_in_nxt;
   end

   assign ctl_out   = ctl_ff;
   assign left_out  = left_ff;
   assign stamp_out = stamp_ff;
   assign cnt_out   = cnt_ff;

endmodule

// ===== rtl/core/paged_frame_allocator.sv =====
`timescale 1ns / 1ps
// Paged frame allocator: a row of frame cells swept by release and allocation waves.
//
// Arrivals are answered in the cycle after the transfer (with one result). A tick
// launches a release wave into the row of FRAMES frame cells; it moves one cell
// per cycle, and admissions start once it has left the last cell (S_REL).
// Each admitted process then takes a queue head read (S_READ) and a result (S_ADMIT,
// which waits for a free output) and launches an allocation wave that trails behind
// on its own, taking the lowest free frames. The tick-done result closes the tick.
// A write to either register reinitializes the frames, queue, time and FSM in the
// same cycle, using the new register values; a result already waiting on the output
// is kept. The free count is total frames minus busy frames.
module paged_frame_allocator
   import pfa_pkg::*;
#(
   parameter int FRAMES      = 64,
   parameter int QUEUE_DEPTH = 16,
   parameter int TIME_BITS   = 24
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [15:0] req_process_id,
   input  logic [15:0] req_lifetime,
   input  logic [15:0] req_mem_request,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_process_id_res,
   output logic [9:0]  rsp_pages,
   output logic [23:0] rsp_end_time,
   output logic [6:0]  rsp_free_frames,
   output logic [6:0]  rsp_released_frames,
   output logic        rsp_last,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int FW  = $clog2(FRAMES + 1);
   localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW  = 32 + PAGE_W;

   // FSM codes
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_REL   = 3'd1;  // release wave in flight
   localparam logic [2:0] S_READ  = 3'd2;  // queue head read
   localparam logic [2:0] S_ADMIT = 3'd3;  // admit head or close tick

   logic [2:0]           state_ff, state_in;
   logic [15:0]          mem_size_ff, mem_size_in;
   logic [1:0]           page_sel_ff, page_sel_in;
   logic [FW-1:0]        busy_count_ff, busy_count_in;
   logic [QW-1:0]        q_head_ff, q_head_in;
   logic [QCW-1:0]       q_count_ff, q_count_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [FW-1:0]        released_ff, released_in;

   tok_ctl_type          inj_ctl_ff, inj_ctl_in;
   logic [PAGE_W-1:0]    inj_left_ff, inj_left_in;
   logic [TIME_BITS-1:0] inj_stamp_ff, inj_stamp_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_kind_ff, rsp_kind_in;
   logic [15:0]          rsp_pid_ff, rsp_pid_in;
   logic [9:0]           rsp_pages_ff, rsp_pages_in;
   logic [23:0]          rsp_end_ff, rsp_end_in;
   logic [6:0]           rsp_free_ff, rsp_free_in;
   logic [6:0]           rsp_rel_ff, rsp_rel_in;
   logic                 rsp_last_ff, rsp_last_in;

   // wait queue: {pid, lifetime, pages}
   logic [EW-1:0]        q_mem [QUEUE_DEPTH];
   logic [EW-1:0]        q_rd_ff;
   logic                 q_we;
   logic [QW-1:0]        q_waddr;
   logic [EW-1:0]        q_wdata;
   logic [QCW:0]         tail_sum;

   // frame cell row
   tok_ctl_type          ctl_chain   [FRAMES+1];
   logic [PAGE_W-1:0]    left_chain  [FRAMES+1];
   logic [TIME_BITS-1:0] stamp_chain [FRAMES+1];
   logic [FW-1:0]        cnt_chain   [FRAMES+1];
   logic [FRAMES-1:0]    cell_en;

   logic [1:0]           div_sh;
   logic [28:0]          tot_prod, tot_quo;
   logic [FW-1:0]        total;
   logic [FW-1:0]        free_now;
   logic [9:0]           ps_m1;
   logic [16:0]          pg_num;
   logic [29:0]          pg_prod, pg_quo;
   logic [PAGE_W-1:0]    req_pages;
   logic                 req_fire, out_free, cfg_hit;
   logic [15:0]          hd_pid, hd_life;
   logic [PAGE_W-1:0]    hd_pages;
   logic [TIME_BITS-1:0] hd_end;
   logic [31:0]          end_wide, now_wide, free_wide, rel_wide;

   // Page size divide by reciprocal
   always_comb begin
      unique case (page_sel_ff)
         PSEL_100: begin
            div_sh = 2'd0;
            ps_m1  = 10'd99;
         end
         PSEL_200: begin
            div_sh = 2'd1;
            ps_m1  = 10'd199;
         end
         default: begin
            div_sh = 2'd2;   // select three behaves as 400 bytes
            ps_m1  = 10'd399;
         end
      endcase
   end

   // shift off the power-of-two part of the page size, then divide by 25
   assign tot_prod = 29'(mem_size_ff >> (2 + int'(div_sh))) * 29'(RECIP);
   assign tot_quo  = tot_prod >> RECIP_SHIFT;
   assign total    = (32'(tot_quo) > 32'(FRAMES)) ? FW'(FRAMES) : FW'(tot_quo);
   assign free_now = total - busy_count_ff;

   assign pg_num    = 17'(req_mem_request) + 17'(ps_m1);
   assign pg_prod   = 30'(pg_num >> (2 + int'(div_sh))) * 30'(RECIP);
   assign pg_quo    = pg_prod >> RECIP_SHIFT;
   assign req_pages = pg_quo[PAGE_W-1:0];

   assign {hd_pid, hd_life, hd_pages} = q_rd_ff;
   assign hd_end = TIME_BITS'(32'(now_ff) + 32'(hd_life));

   assign tail_sum = (QCW+1)'(q_head_ff) + (QCW+1)'(q_count_ff);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign cfg_hit   = csr_valid && csr_ready &&
                      (csr_index == CSR_MEM_SIZE || csr_index == CSR_PAGE_SEL);

   always_comb begin
      state_in      = state_ff;
      mem_size_in   = mem_size_ff;
      page_sel_in   = page_sel_ff;
      busy_count_in = busy_count_ff;
      q_head_in     = q_head_ff;
      q_count_in    = q_count_ff;
      now_in        = now_ff;
      released_in   = released_ff;
      inj_ctl_in    = '0;
      inj_left_in   = inj_left_ff;
      inj_stamp_in  = inj_stamp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_pid_in    = rsp_pid_ff;
      rsp_pages_in  = rsp_pages_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_rel_in    = rsp_rel_ff;
      rsp_last_in   = rsp_last_ff;
      q_we          = 1'b0;
      q_waddr       = (32'(tail_sum) >= QUEUE_DEPTH) ?
                      QW'(tail_sum - (QCW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
      q_wdata       = {req_process_id, req_lifetime, req_pages};
      end_wide      = 32'(hd_end);
      now_wide      = 32'(now_ff);
      free_wide     = 32'(free_now);
      rel_wide      = 32'(released_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_operation == OP_TICK) begin
                  // launch the release wave stamped with the current time
                  inj_ctl_in   = '{valid: 1'b1, alloc: 1'b0};
                  inj_left_in  = '0;
                  inj_stamp_in = now_ff;
                  state_in     = S_REL;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_pid_in   = req_process_id;
                  rsp_pages_in = req_pages;
                  rsp_end_in   = '0;
                  rsp_free_in  = free_wide[6:0];
                  rsp_rel_in   = '0;
                  rsp_last_in  = 1'b1;
                  if (req_mem_request > mem_size_ff) begin
                     rsp_kind_in = KIND_OVERSIZED;
                  end else if (32'(q_count_ff) == QUEUE_DEPTH) begin
                     rsp_kind_in = KIND_FULL;
                  end else begin
                     rsp_kind_in = KIND_QUEUED;
                     q_we        = 1'b1;
                     q_count_in  = q_count_ff + QCW'(1);
                  end
               end
            end
         end
         S_REL: begin
            if (ctl_chain[FRAMES].valid && !ctl_chain[FRAMES].alloc) begin
               released_in   = cnt_chain[FRAMES];
               busy_count_in = busy_count_ff - cnt_chain[FRAMES];
               state_in      = S_READ;
            end
         end
         S_READ: begin
            state_in = S_ADMIT;
         end
         S_ADMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rel_in   = rel_wide[6:0];
               if (q_count_ff != '0 && 32'(hd_pages) <= free_wide) begin
                  // admit head; its allocation wave runs behind on its own
                  inj_ctl_in    = '{valid: 1'b1, alloc: 1'b1};
                  inj_left_in   = hd_pages;
                  inj_stamp_in  = hd_end;
                  busy_count_in = busy_count_ff + FW'(hd_pages);
                  free_wide     = free_wide - 32'(hd_pages);
                  rsp_kind_in   = KIND_ADMITTED;
                  rsp_pid_in    = hd_pid;
                  rsp_pages_in  = hd_pages;
                  rsp_end_in    = end_wide[23:0];
                  rsp_free_in   = free_wide[6:0];
                  rsp_last_in   = 1'b0;
                  q_head_in     = (32'(q_head_ff) == QUEUE_DEPTH - 1) ?
                                  '0 : q_head_ff + QW'(1);
                  q_count_in    = q_count_ff - QCW'(1);
                  state_in      = S_READ;
               end else begin
                  rsp_kind_in  = KIND_TICK_DONE;
                  rsp_pid_in   = '0;
                  rsp_pages_in = '0;
                  rsp_end_in   = now_wide[23:0];
                  rsp_free_in  = free_wide[6:0];
                  rsp_last_in  = 1'b1;
                  now_in       = now_ff + TIME_BITS'(1);
                  state_in     = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register write reinitializes the frames, queue, time and FSM
      if (cfg_hit) begin
         if (csr_index == CSR_MEM_SIZE) begin
            mem_size_in = csr_data;
         end else begin
            page_sel_in = csr_data[1:0];
         end
         busy_count_in = '0;
         q_head_in     = '0;
         q_count_in    = '0;
         now_in        = '0;
         inj_ctl_in    = '0;
         state_in      = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mem_size_ff   <= 16'd6400;
         page_sel_ff   <= PSEL_100;
         busy_count_ff <= '0;
         q_head_ff     <= '0;
         q_count_ff    <= '0;
         now_ff        <= '0;
         inj_ctl_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mem_size_ff   <= mem_size_in;
         page_sel_ff   <= page_sel_in;
         busy_count_ff <= busy_count_in;
         q_head_ff     <= q_head_in;
         q_count_ff    <= q_count_in;
         now_ff        <= now_in;
         inj_ctl_ff    <= inj_ctl_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      released_ff  <= released_in;
      inj_left_ff  <= inj_left_in;
      inj_stamp_ff <= inj_stamp_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_pid_ff   <= rsp_pid_in;
      rsp_pages_ff <= rsp_pages_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_free_ff  <= rsp_free_in;
      rsp_rel_ff   <= rsp_rel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // wait queue storage, registered head read
   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[q_waddr] <= q_wdata;
      end
      q_rd_ff <= q_mem[q_head_ff];
   end

   // cell row: wave enters at cell 0 and exits after passing every cell register
   assign ctl_chain[0]   = inj_ctl_ff;
   assign left_chain[0]  = inj_left_ff;
   assign stamp_chain[0] = inj_stamp_ff;
   assign cnt_chain[0]   = '0;

   for (genvar g = 0; g < FRAMES; g++) begin : g_cell
      assign cell_en[g] = (FW'(g) < total);
      pfa_cell #(
         .TIME_BITS (TIME_BITS),
         .CNT_W     (FW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .clear     (cfg_hit),
         .enable    (cell_en[g]),
         .ctl_in    (ctl_chain[g]),
         .left_in   (left_chain[g]),
         .stamp_in  (stamp_chain[g]),
         .cnt_in    (cnt_chain[g]),
         .ctl_out   (ctl_chain[g+1]),
         .left_out  (left_chain[g+1]),
         .stamp_out (stamp_chain[g+1]),
         .cnt_out   (cnt_chain[g+1])
      );
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_process_id_res  = rsp_pid_ff;
   assign rsp_pages           = rsp_pages_ff;
   assign rsp_end_time        = rsp_end_ff;
   assign rsp_free_frames     = rsp_free_ff;
   assign rsp_released_frames = rsp_rel_ff;
   assign rsp_last            = rsp_last_ff;

`ifndef ASSERT_OFF
   a_busy_le_total: assert property (@(posedge clock) disable iff (reset)
      busy_count_ff <= total)
      else $error("busy frame count exceeds frame total");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      32'(q_count_ff) <= QUEUE_DEPTH)
      else $error("queue count beyond depth");

   a_tick_starts_release: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_operation == OP_TICK && !cfg_hit |=> state_ff == S_REL)
      else $error("tick did not start release wave");

   a_admit_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_ADMITTED |-> !rsp_last_ff)
      else $error("admitted result marked last");
`endif

endmodule

// ===== tb/sv/paged_frame_allocator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the paged frame allocator.
module paged_frame_allocator_test;
   import pfa_pkg::*;

   localparam int NFRAMES     = 64;
   localparam int QDEPTH      = 16;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 3000;
   // settle time after the last expected result, so trailing waves leave the cell row
   localparam int SETTLE      = 2 * NFRAMES + 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = OP_ARRIVAL;
   logic [15:0] req_process_id = '0;
   logic [15:0] req_lifetime = '0;
   logic [15:0] req_mem_request = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [15:0] rsp_process_id_res;
   logic [9:0]  rsp_pages;
   logic [23:0] rsp_end_time;
   logic [6:0]  rsp_free_frames;
   logic [6:0]  rsp_released_frames;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_MEM_SIZE;
   logic [15:0] csr_data = '0;

   paged_frame_allocator i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_process_id     (req_process_id),
      .req_lifetime       (req_lifetime),
      .req_mem_request    (req_mem_request),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_process_id_res (rsp_process_id_res),
      .rsp_pages          (rsp_pages),
      .rsp_end_time       (rsp_end_time),
      .rsp_free_frames    (rsp_free_frames),
      .rsp_released_frames(rsp_released_frames),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   // One expected result transfer
   typedef struct {
      logic [2:0]  kind;
      logic [15:0] pid;
      logic [9:0]  pages;
      logic [23:0] end_time;
      logic [6:0]  free_frames;
      logic [6:0]  released;
      logic        last;
   } alloc_result_type;

   alloc_result_type pending_results[$];

   // Shadow of the allocator: registers, frame table, wait queue, clock
   logic [15:0] mem_size_sh;
   logic [1:0]  page_sel_sh;
   logic        frame_used[NFRAMES];
   logic [23:0] frame_expiry[NFRAMES];
   int          wait_pid[QDEPTH];
   int          wait_life[QDEPTH];
   int          wait_pages[QDEPTH];
   int          wait_head, wait_count, free_sh;
   logic [23:0] now_sh;

   int send_idle_pct = 0;   // chance in 100 of an idle cycle before an item
   int recv_stall_pct = 0;  // chance in 100 that rsp_ready is low
   int hold_starts = 0;     // bumped by a test to start a long hold-off
   int hold_seen = 0;
   int hold_left = 0;       // long receiver hold-off, counted down below
   int mismatches = 0;
   int cycles = 0;

   function automatic int page_bytes();
      if (page_sel_sh == PSEL_100) return 100;
      if (page_sel_sh == PSEL_200) return 200;
      return 400;   // selects 2 and 3 both mean 400
   endfunction

   function automatic int frame_count();
      int n;
      n = mem_size_sh / page_bytes();
      return n > NFRAMES ? NFRAMES : n;
   endfunction

   // Any register write clears everything back to reset, with new sizing
   task automatic clear_shadow();
      for (int i = 0; i < NFRAMES; i++) begin
         frame_used[i] = 1'b0;
         frame_expiry[i] = '0;
      end
      wait_head = 0;
      wait_count = 0;
      now_sh = '0;
      free_sh = frame_count();
   endtask

   task automatic push_result(logic [2:0] kind, int pid, int pages, logic [23:0] endt,
                              int rel, logic last);
      alloc_result_type r;
      r.kind = kind;
      r.pid = pid[15:0];
      r.pages = pages[9:0];
      r.end_time = endt;
      r.free_frames = free_sh[6:0];
      r.released = rel[6:0];
      r.last = last;
      pending_results = {pending_results, r};
   endtask

   // Work out the results of one accepted item
   task automatic predict_allocation(logic op, int pid, int life, int req);
      int ps, pages, slot, total, released, left, w;
      logic [23:0] endt;
      if (op == OP_ARRIVAL) begin
         ps = page_bytes();
         pages = (req + ps - 1) / ps;
         if (req > mem_size_sh) begin
            push_result(KIND_OVERSIZED, pid, pages, '0, 0, 1'b1);
         end else if (wait_count >= QDEPTH) begin
            push_result(KIND_FULL, pid, pages, '0, 0, 1'b1);
         end else begin
            slot = (wait_head + wait_count) % QDEPTH;
            wait_pid[slot] = pid;
            wait_life[slot] = life;
            wait_pages[slot] = pages;
            wait_count++;
            push_result(KIND_QUEUED, pid, pages, '0, 0, 1'b1);
         end
         return;
      end
      total = frame_count();
      released = 0;
      for (int i = 0; i < NFRAMES; i++) begin
         if (frame_used[i] && frame_expiry[i] == now_sh) begin
            frame_used[i] = 1'b0;
            released++;
            if (free_sh < NFRAMES) free_sh++;
         end
      end
      // admit heads in order; a head that does not fit blocks the rest
      while (wait_count > 0) begin
         w = wait_head;
         if (wait_pages[w] > free_sh) break;
         endt = now_sh + 24'(wait_life[w]);
         left = wait_pages[w];
         for (int i = 0; i < total && left > 0; i++) begin
            if (!frame_used[i]) begin
               frame_used[i] = 1'b1;
               frame_expiry[i] = endt;
               left--;
               free_sh--;
            end
         end
         push_result(KIND_ADMITTED, wait_pid[w], wait_pages[w], endt, released, 1'b0);
         wait_head = (wait_head + 1) % QDEPTH;
         wait_count--;
      end
      push_result(KIND_TICK_DONE, 0, 0, now_sh, released, 1'b1);
      now_sh = now_sh + 24'd1;
   endtask

   // Offer one item and hold it until the transfer happens
   task automatic send_item(logic op, int pid, int life, int req);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_process_id <= pid[15:0];
      req_lifetime <= life[15:0];
      req_mem_request <= req[15:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_allocation(op, pid, life, req);
   endtask

   task automatic arrive(int pid, int life, int req);
      send_item(OP_ARRIVAL, pid, life, req);
   endtask

   task automatic tick();
      send_item(OP_TICK, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                $urandom_range(16'hFFFF));
   endtask

   // Drop valid, wait for all results, then let trailing waves finish
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller drops it after the last write
   task automatic write_csr(logic [1:0] idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[15:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_MEM_SIZE) mem_size_sh = value[15:0];
      else page_sel_sh = value[1:0];
      clear_shadow();
   endtask

   task automatic configure(int mem, int sel);
      drain();
      write_csr(CSR_MEM_SIZE, mem);
      write_csr(CSR_PAGE_SEL, sel);
      csr_valid <= 1'b0;
   endtask

   // Field extremes, every kind of result, queue overflow, blocking head
   task automatic test_directed();
      arrive(16'h0000, 0, 0);           // zero pages, zero lifetime
      arrive(16'hFFFF, 16'hFFFF, 6400); // whole memory
      arrive(16'h1234, 3, 6401);        // one byte too many: rejected
      arrive(16'h5678, 3, 65535);       // rejected
      tick();                           // zero-page one and 64-page one admitted
      arrive(16'hAAAA, 2, 1);
      tick();                           // blocked: no frames free
      for (int i = 0; i < QDEPTH + 2; i++) arrive(16'h0100 + i, 1, 99 + i);
      tick();
   endtask

   task automatic test_page_sizes();
      configure(65535, PSEL_100);
      arrive(16'h0042, 1, 65535);       // 656 pages: blocks the queue for good
      arrive(16'h0043, 1, 100);
      tick();
      tick();
      configure(0, PSEL_200);
      arrive(16'h0050, 0, 1);           // rejected
      arrive(16'h0051, 0, 0);           // zero pages fit even with no memory
      tick();
      configure(65535, 2'd3);           // select three acts as 400
      arrive(16'h0060, 2, 401);
      arrive(16'h0061, 1, 25600);
      tick();
      tick();
      tick();
      configure(1000, PSEL_400);
      arrive(16'h0070, 1, 800);
      tick();
      tick();
   endtask

   // Mostly well-formed traffic with short lives so frames cycle through
   task automatic random_traffic(int count);
      int life, req;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 35) begin
            tick();
         end else begin
            if ($urandom_range(9) < 8) life = $urandom_range(1, 6);
            else life = $urandom_range(16'hFFFF);
            if ($urandom_range(9) < 8) req = $urandom_range(mem_size_sh / 4);
            else req = $urandom_range(16'hFFFF);
            arrive($urandom_range(16'hFFFF), life, req);
         end
      end
   endtask

   task automatic test_random_phases();
      configure(6400, PSEL_100);
      send_idle_pct = 0;  recv_stall_pct = 0;  random_traffic(50);
      configure(12800, PSEL_200);
      send_idle_pct = 88; recv_stall_pct = 0;  random_traffic(40);
      configure(3000, PSEL_100);
      send_idle_pct = 0;  recv_stall_pct = 88; random_traffic(40);
      configure(65535, PSEL_400);
      send_idle_pct = 36; recv_stall_pct = 36; random_traffic(50);
   endtask

   // Receiver holds off while the sender keeps offering: input must stall
   task automatic test_backpressure();
      configure(6400, PSEL_100);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_starts++;
      random_traffic(40);
   endtask

   // Long hold-off counter
   always @(posedge clock) begin
      if (hold_seen != hold_starts) begin
         hold_seen <= hold_starts;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result checker; also decides rsp_ready for the next cycle
   always @(posedge clock) begin
      alloc_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer: kind %0d pid %h", rsp_kind,
                        rsp_process_id_res);
         end else begin
            e = pending_results.pop_front();
            if (rsp_kind !== e.kind || rsp_process_id_res !== e.pid ||
                rsp_pages !== e.pages || rsp_end_time !== e.end_time ||
                rsp_free_frames !== e.free_frames ||
                rsp_released_frames !== e.released || rsp_last !== e.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp kind %0d pid %h pages %0d end %0d free %0d",
                           e.kind, e.pid, e.pages, e.end_time, e.free_frames,
                           " rel %0d last %0b", e.released, e.last);
                  $display("          got kind %0d pid %h pages %0d end %0d free %0d",
                           rsp_kind, rsp_process_id_res, rsp_pages, rsp_end_time,
                           rsp_free_frames, " rel %0d last %0b",
                           rsp_released_frames, rsp_last);
               end
            end
         end
      end
      rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("paged_frame_allocator_test failed");
         $finish;
      end
   end

   initial begin
      mem_size_sh = 16'd6400;
      page_sel_sh = PSEL_100;
      clear_shadow();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_page_sizes();
      test_random_phases();
      test_backpressure();
      drain();
      if (mismatches == 0 && pending_results.size() == 0)
         $display("paged_frame_allocator_test passed");
      else
         $display("paged_frame_allocator_test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/pfa_pkg.sv
rtl/core/pfa_cell.sv
rtl/core/paged_frame_allocator.sv
tb/sv/paged_frame_allocator_test.sv
